// ===== src/embedding_bag_sum_macros.svh =====
// Assertion macros for the design file that checks itself.
`ifndef EMBEDDING_BAG_SUM_MACROS_SVH
`define EMBEDDING_BAG_SUM_MACROS_SVH

// Check a consequence in the same cycle.
`define EBS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("embedding_bag_sum: same-cycle check failed");

// Check a consequence in the next cycle.
`define EBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("embedding_bag_sum: next-cycle check failed");

`endif

// ===== src/ebs_pkg.sv =====
package ebs_pkg;

  localparam int DIM        = 16;
  localparam int TABLE_ROWS = 1024;
  localparam int LANE_W     = $clog2(DIM);
  localparam int ROW_AW     = $clog2(TABLE_ROWS);

  localparam int OPC_W = 2;
  localparam int ROW_W = 10;
  localparam int COL_W = 6;
  localparam int FP_W  = 32;

  localparam logic [OPC_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OPC_W-1:0] OP_ACCUM = 2'd1;
  localparam logic [OPC_W-1:0] OP_EMPTY = 2'd2;

  localparam logic [FP_W-1:0] CANON_NAN = 32'h7FC0_0000;

  typedef logic [FP_W-1:0] word_t;
  typedef word_t [DIM-1:0] row_t;

  typedef struct packed {
    logic fire;  // stage holds an item that advances this cycle
    logic add;   // add the row read from the table
    logic emit;  // close the bag after the add
  } ebs_s1_ctrl_t;

  // binary32 add, round to nearest even, canonical NaN, subnormals kept
  function automatic word_t fp32_add(input word_t a, input word_t b);
    word_t       x;
    word_t       y;
    logic        a_nan;
    logic        b_nan;
    logic        a_inf;
    logic        b_inf;
    logic [7:0]  ex;
    logic [7:0]  ey;
    logic [7:0]  d;
    logic [26:0] ax;
    logic [26:0] ay;
    logic [26:0] ay_sh;
    logic        st;
    logic [27:0] sum;
    logic [26:0] nm;
    logic [8:0]  ne;
    logic [4:0]  lz;
    logic        found;
    logic [8:0]  sh;
    logic [7:0]  eenc;
    logic [30:0] pk;
    logic        rnd;
    a_nan = (&a[30:23]) && (|a[22:0]);
    b_nan = (&b[30:23]) && (|b[22:0]);
    a_inf = (&a[30:23]) && !(|a[22:0]);
    b_inf = (&b[30:23]) && !(|b[22:0]);
    if (a_nan || b_nan || (a_inf && b_inf && (a[31] ^ b[31]))) return CANON_NAN;
    if (a_inf) return a;
    if (b_inf) return b;
    if (a[30:0] >= b[30:0]) begin
      x = a;
      y = b;
    end else begin
      x = b;
      y = a;
    end
    ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    ax = {(|x[30:23]), x[22:0], 3'b000};
    ay = {(|y[30:23]), y[22:0], 3'b000};
    d  = ex - ey;
    if (d >= 8'd27) begin
      ay_sh = '0;
      st    = |ay;
    end else begin
      ay_sh = ay >> d;
      st    = |(ay & ~(27'h7FF_FFFF << d));
    end
    ay_sh[0] = ay_sh[0] | st;
    if (x[31] == y[31]) sum = {1'b0, ax} + {1'b0, ay_sh};
    else                sum = {1'b0, ax} - {1'b0, ay_sh};
    if (sum == 28'd0) return {x[31] & y[31], 31'd0};
    if (sum[27]) begin
      nm = {sum[27:2], sum[1] | sum[0]};
      ne = {1'b0, ex} + 9'd1;
    end else begin
      lz    = '0;
      found = 1'b0;
      for (int i = 26; i >= 0; i--) begin
        if (!found) begin
          if (sum[i]) found = 1'b1;
          else        lz = lz + 5'd1;
        end
      end
      sh = ({4'd0, lz} < ({1'b0, ex} - 9'd1)) ? {4'd0, lz} : ({1'b0, ex} - 9'd1);
      nm = sum[26:0] << sh;
      ne = {1'b0, ex} - sh;
    end
    if (ne >= 9'd255) return {x[31], 8'hFF, 23'd0};
    eenc = nm[26] ? ne[7:0] : 8'd0;
    pk   = {eenc, nm[25:3]};
    rnd  = nm[2] & (nm[1] | nm[0] | nm[3]);
    pk   = pk + {30'd0, rnd};
    return {x[31], pk};
  endfunction

endpackage

// ===== src/ebs_in_if.sv =====
interface ebs_in_if import ebs_pkg::*;;
  logic             valid;
  logic             ready;
  logic [OPC_W-1:0] opcode;
  logic [ROW_W-1:0] row_index;
  logic [COL_W-1:0] column;
  logic [FP_W-1:0]  value_bits;
  logic             end_of_bag;

  modport source (output valid, opcode, row_index, column, value_bits, end_of_bag,
                  input ready);
  modport sink   (input valid, opcode, row_index, column, value_bits, end_of_bag,
                  output ready);
endinterface

// ===== src/ebs_out_if.sv =====
interface ebs_out_if import ebs_pkg::*;;
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] result_column;
  logic [FP_W-1:0]  sum_bits;
  logic             last_column;

  modport source (output valid, result_column, sum_bits, last_column, input ready);
  modport sink   (input valid, result_column, sum_bits, last_column, output ready);
endinterface

// ===== src/ebs_ram.sv =====
module ebs_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== src/ebs_accum.sv =====
module ebs_accum import ebs_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  ebs_s1_ctrl_t ctrl,
  input  row_t         row_data,
  output row_t         bag_sums
);
  row_t acc_r;
  row_t acc_nxt;
  row_t added;

  always_comb begin
    for (int l = 0; l < DIM; l++) begin
      added[l] = ctrl.add ? fp32_add(acc_r[l], row_data[l]) : acc_r[l];
    end
    bag_sums = added;
    acc_nxt  = acc_r;
    if (ctrl.fire) acc_nxt = ctrl.emit ? '0 : added;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) acc_r <= '0;
    else        acc_r <= acc_nxt;
  end
endmodule

// ===== src/ebs_drain.sv =====
module ebs_drain import ebs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  row_t             bag_sums,
  output logic             free,
  ebs_out_if.source        out_ch
);
  row_t              sh_r;
  row_t              sh_nxt;
  logic [LANE_W-1:0] cnt_r;
  logic [LANE_W-1:0] cnt_nxt;
  logic              busy_r;
  logic              busy_nxt;
  logic              fire;
  logic              at_last;

  assign at_last = (cnt_r == LANE_W'(DIM - 1));
  assign fire    = busy_r && out_ch.ready;
  assign free    = !busy_r || (fire && at_last);

  always_comb begin
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (load) begin
      sh_nxt   = bag_sums;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (fire) begin
      for (int l = 0; l < DIM - 1; l++) sh_nxt[l] = sh_r[l+1];
      cnt_nxt = cnt_r + LANE_W'(1);
      if (at_last) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    sh_r <= sh_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign out_ch.valid         = busy_r;
  assign out_ch.result_column = COL_W'(cnt_r);
  assign out_ch.sum_bits      = sh_r[0];
  assign out_ch.last_column   = at_last;
endmodule

// ===== src/embedding_bag_sum.sv =====
// Channel | Dir | Words carried
// --------+-----+--------------------------------------------------------
// in_ch   | in  | opcode, row_index, column, value_bits, end_of_bag
// out_ch  | out | result_column, sum_bits, last_column (DIM words per bag)
//
// One input word per cycle while stage 1 is not held: accept registers the row read
// from DIM column RAMs; stage 1 then adds it into DIM binary32 accumulators, one
// adder per column. A closing word loads the sums into the output shift bank in that
// cycle; the bank drains one word per cycle while out_ch.ready is high, and a further
// close waits only while the bank still holds an earlier bag.
// Reset (rst_n low, synchronous) clears accumulators and control; table undefined.
module embedding_bag_sum import ebs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ebs_in_if.sink    in_ch,
  ebs_out_if.source out_ch
);
`include "embedding_bag_sum_macros.svh"

  logic         accept;
  logic         col_ok;
  logic         row_ok;
  logic         s1_valid_r;
  logic         s1_add_r;
  logic         s1_emit_r;
  logic         s1_go;
  logic         snap_free;
  logic         emit_fire;
  ebs_s1_ctrl_t s1_ctrl;
  row_t         row_data;
  row_t         bag_sums;

  assign accept = in_ch.valid && in_ch.ready;
  assign col_ok = {1'b0, in_ch.column} < (COL_W + 1)'(DIM);
  assign row_ok = {1'b0, in_ch.row_index} < (ROW_W + 1)'(TABLE_ROWS);

  // Stage 1 stalls only when it closes a bag and the drain bank is full.
  assign s1_go       = !s1_emit_r || snap_free;
  assign in_ch.ready = !s1_valid_r || s1_go;

  // One table RAM per column; write the addressed column, read the whole row.
  for (genvar l = 0; l < DIM; l++) begin : g_lane
    ebs_ram #(.DEPTH(TABLE_ROWS), .WIDTH(FP_W)) u_ram (
      .clk   (clk),
      .we    (accept && (in_ch.opcode == OP_WRITE) && col_ok && row_ok &&
              (in_ch.column[LANE_W-1:0] == LANE_W'(l))),
      .waddr (ROW_AW'(in_ch.row_index)),
      .wdata (in_ch.value_bits),
      .re    (accept),
      .raddr (ROW_AW'(in_ch.row_index)),
      .rdata (row_data[l])
    );
  end

  // Advance only words that touch the accumulators; drop writes and opcode 3.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_add_r   <= 1'b0;
      s1_emit_r  <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= accept && ((in_ch.opcode == OP_ACCUM) || (in_ch.opcode == OP_EMPTY));
      s1_add_r   <= (in_ch.opcode == OP_ACCUM) && row_ok;
      s1_emit_r  <= ((in_ch.opcode == OP_ACCUM) && in_ch.end_of_bag) ||
                    (in_ch.opcode == OP_EMPTY);
    end
  end

  assign s1_ctrl.fire = s1_valid_r && s1_go;
  assign s1_ctrl.add  = s1_add_r;
  assign s1_ctrl.emit = s1_emit_r;
  assign emit_fire    = s1_ctrl.fire && s1_emit_r;

  ebs_accum u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (s1_ctrl),
    .row_data (row_data),
    .bag_sums (bag_sums)
  );

  ebs_drain u_drain (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (emit_fire),
    .bag_sums (bag_sums),
    .free     (snap_free),
    .out_ch   (out_ch)
  );

  // A held stage never takes a new word.
  `EBS_ASSERT_NOW(a_no_overrun, accept, !(s1_valid_r && !s1_go))
  // A closed bag starts its output at column zero.
  `EBS_ASSERT_NEXT(a_bag_start, emit_fire, out_ch.valid && (out_ch.result_column == '0))
  // After the last column, the bank is empty or a new bag begins.
  `EBS_ASSERT_NEXT(a_bag_end, out_ch.valid && out_ch.ready && out_ch.last_column,
                   !out_ch.valid || (out_ch.result_column == '0))
endmodule

// ===== verif/embedding_bag_sum_tb.sv =====
module embedding_bag_sum_tb;
  import ebs_pkg::*;

  localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 4 * DIM + 16;

  typedef struct {
    logic [COL_W-1:0] col;
    word_t            sum;
    logic             last;
  } pooled_t;

  // Widen a binary32 word into a real; every binary32 value is exact in a double.
  function automatic real sp_to_real(input word_t w);
    real v;
    if (w[30:23] == 8'd0) begin
      v = w[22:0];
      v = v * $bitstoreal({1'b0, 11'd874, 52'd0});  // times 2**-149
      if (w[31]) v = -v;
      if (w[22:0] == 23'd0) v = $bitstoreal({w[31], 63'd0});
    end else begin
      v = $bitstoreal({w[31], 11'(int'(w[30:23]) + 896), w[22:0], 29'd0});
    end
    return v;
  endfunction

  // Round a double (a sum of two binary32 values) to binary32, nearest even.
  function automatic word_t real_to_sp(input real r);
    logic [63:0] d;
    logic [63:0] m;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] packed_w;
    int          e;
    int          sh;
    d = $realtobits(r);
    if (d[62:0] == 63'd0) return {d[63], 31'd0};
    e = int'(d[62:52]) - 1023;
    if (e > 127) return {d[63], 8'hFF, 23'd0};
    m  = {11'd0, 1'b1, d[51:0]};
    sh = (e >= -126) ? 29 : 29 + (-126 - e);
    if (sh > 60) return {d[63], 31'd0};
    q    = m >> sh;
    rem  = m & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    packed_w = (e >= -126) ? (64'(e + 126) << 23) + q : q;
    if (packed_w >= 64'h7F80_0000) return {d[63], 8'hFF, 23'd0};
    return {d[63], packed_w[30:0]};
  endfunction

  function automatic word_t sp_sum(input word_t a, input word_t b);
    logic a_nan, b_nan, a_inf, b_inf;
    word_t r;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 0);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 0);
    if (a_nan || b_nan) return CANON_NAN;
    if (a_inf && b_inf) return (a[31] != b[31]) ? CANON_NAN : a;
    if (a_inf) return a;
    if (b_inf) return b;
    r = real_to_sp(sp_to_real(a) + sp_to_real(b));
    return r;
  endfunction

  // Mirror of the pooling state; queues the column sums each bag close yields.
  class bag_scoreboard;
    word_t   rows[TABLE_ROWS][DIM];
    word_t   acc[DIM];
    pooled_t pending[$];
    int      errors;

    function new();
      errors = 0;
      foreach (acc[c]) acc[c] = '0;
    endfunction

    function void close_bag();
      pooled_t p;
      for (int c = 0; c < DIM; c++) begin
        p.col  = COL_W'(c);
        p.sum  = acc[c];
        p.last = (c == DIM - 1);
        pending.push_back(p);
        acc[c] = '0;
      end
    endfunction

    function void note_word(input logic [OPC_W-1:0] op, input logic [ROW_W-1:0] row,
                            input logic [COL_W-1:0] col, input word_t val,
                            input logic eob);
      case (op)
        OP_WRITE: begin
          if (row < TABLE_ROWS && col < DIM) rows[row][col] = val;
        end
        OP_ACCUM: begin
          if (row < TABLE_ROWS)
            for (int c = 0; c < DIM; c++) acc[c] = sp_sum(acc[c], rows[row][c]);
          if (eob) close_bag();
        end
        OP_EMPTY: close_bag();
        default: ;
      endcase
    endfunction

    function void check_word(input logic [COL_W-1:0] col, input word_t sum,
                             input logic last);
      pooled_t p;
      if (pending.size() == 0) begin
        $error("unexpected word: result_column %0d sum_bits %h", col, sum);
        errors++;
        return;
      end
      p = pending.pop_front();
      if (col !== p.col) begin
        $error("result_column: expected %0d, got %0d", p.col, col);
        errors++;
      end
      if (sum !== p.sum) begin
        $error("sum_bits: expected %h, got %h", p.sum, sum);
        errors++;
      end
      if (last !== p.last) begin
        $error("last_column: expected %0d, got %0d", p.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  ebs_in_if  in_ch();
  ebs_out_if out_ch();

  embedding_bag_sum u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bag_scoreboard sb = new();
  logic [DIM-1:0] written[TABLE_ROWS];  // columns loaded so far, per row
  int   full_rows[$];                   // rows safe to accumulate
  logic no_gaps;                        // hold both sides busy during a burst
  int   cycles;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Run guard: stop a hung run.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("embedding_bag_sum_tb failed");
      $finish;
    end
  end

  // Sink: drop ready at random on the falling edge, check on the rising edge.
  always @(negedge clk) begin
    if (rst_n) out_ch.ready <= no_gaps || ($urandom_range(99) >= 25);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_word(out_ch.result_column, out_ch.sum_bits, out_ch.last_column);
  end

  // Drive one word: idle at random first, then hold valid until it is taken.
  task automatic send_word(input logic [OPC_W-1:0] op, input logic [ROW_W-1:0] row,
                           input logic [COL_W-1:0] col, input word_t val,
                           input logic eob);
    @(negedge clk);
    while (!no_gaps && $urandom_range(99) < 25) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.opcode     = op;
    in_ch.row_index  = row;
    in_ch.column     = col;
    in_ch.value_bits = val;
    in_ch.end_of_bag = eob;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_word(op, row, col, val, eob);
    if (op == OP_WRITE && row < TABLE_ROWS && col < DIM && !written[row][col]) begin
      written[row][col] = 1'b1;
      if (&written[row]) full_rows.push_back(int'(row));
    end
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // Mix of ordinary values and the awkward ones: zeros, infinities, NaNs,
  // subnormals, values near overflow.
  function automatic word_t pick_value();
    case ($urandom_range(19))
      0:  return 32'h0000_0000;
      1:  return 32'h8000_0000;
      2:  return 32'h7F80_0000;
      3:  return 32'hFF80_0000;
      4:  return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
      5:  return {1'($urandom_range(1)), 8'h00, 23'($urandom())};
      6:  return {1'($urandom_range(1)), 8'hFE, 23'($urandom())};
      7:  return $urandom();
      default: return {1'($urandom_range(1)), 8'($urandom_range(110, 140)),
                       23'($urandom())};
    endcase
  endfunction

  task automatic load_row(input logic [ROW_W-1:0] row);
    for (int c = 0; c < DIM; c++) send_word(OP_WRITE, row, COL_W'(c), pick_value(), 1'b0);
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  int pick;
  int row_sel;

  initial begin
    foreach (written[r]) written[r] = '0;
    no_gaps          = 1'b0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_WRITE;
    in_ch.row_index  = '0;
    in_ch.column     = '0;
    in_ch.value_bits = '0;
    in_ch.end_of_bag = 1'b0;
    out_ch.ready     = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: an empty bag straight out of reset gives zeros.
    send_word(OP_EMPTY, '0, '0, '0, 1'b0);
    // Row 0 holds the extremes; row 1023 the largest finite values.
    send_word(OP_WRITE, 10'd0, 6'd0, 32'h7F80_0000, 1'b0);
    send_word(OP_WRITE, 10'd0, 6'd1, 32'hFF80_0000, 1'b0);
    send_word(OP_WRITE, 10'd0, 6'd2, 32'h7FC0_0001, 1'b0);
    send_word(OP_WRITE, 10'd0, 6'd3, 32'h0000_0001, 1'b0);
    send_word(OP_WRITE, 10'd0, 6'd4, 32'h8000_0000, 1'b0);
    send_word(OP_WRITE, 10'd0, 6'd5, 32'h807F_FFFF, 1'b0);
    for (int c = 6; c < DIM; c++) send_word(OP_WRITE, 10'd0, COL_W'(c), pick_value(), 1'b1);
    for (int c = 0; c < DIM; c++)
      send_word(OP_WRITE, 10'd1023, COL_W'(c), (c % 2) ? 32'hFF7F_FFFF : 32'h7F7F_FFFF, 1'b0);
    // Ignored writes: columns past the row, one with every column bit set.
    send_word(OP_WRITE, 10'd1023, 6'd63, 32'hFFFF_FFFF, 1'b0);
    send_word(OP_WRITE, 10'd0, 6'd16, 32'h3F80_0000, 1'b0);
    // Overflow to infinity, NaN propagation.
    send_word(OP_ACCUM, 10'd1023, '0, '0, 1'b0);
    send_word(OP_ACCUM, 10'd1023, '0, '0, 1'b0);
    send_word(OP_ACCUM, 10'd0, '0, '0, 1'b1);
    send_word(OP_ACCUM, 10'd0, '0, '0, 1'b0);
    send_word(OP_ACCUM, 10'd0, '0, '0, 1'b0);
    // Empty bag in the middle of a bag emits the partial sums.
    send_word(OP_EMPTY, 10'd1023, 6'd63, 32'hFFFF_FFFF, 1'b1);
    // Unused opcode changes nothing.
    send_word(OP_UNUSED, 10'd1023, 6'd63, 32'hFFFF_FFFF, 1'b1);
    send_word(OP_ACCUM, 10'd1023, '0, '0, 1'b1);

    // Pause until every pooled word is out.
    idle_input();
    wait_drained();

    for (int r = 0; r < 6; r++) load_row(ROW_W'($urandom_range(1, 1022)));

    // Random: mostly well-formed bags over loaded rows, some noise.
    for (int i = 0; i < 230; i++) begin
      no_gaps = (i >= 90 && i < 150);
      pick = $urandom_range(99);
      row_sel = full_rows[$urandom_range(full_rows.size() - 1)];
      if (pick < 60)
        send_word(OP_ACCUM, ROW_W'(row_sel), 6'($urandom()), $urandom(),
                  $urandom_range(99) < 30);
      else if (pick < 75)
        send_word(OP_WRITE, 10'($urandom()), 6'($urandom_range(DIM - 1)), pick_value(),
                  1'($urandom()));
      else if (pick < 82)
        send_word(OP_WRITE, 10'($urandom()), 6'($urandom_range(DIM, 63)), $urandom(),
                  1'($urandom()));
      else if (pick < 92)
        send_word(OP_EMPTY, 10'($urandom()), 6'($urandom()), $urandom(), 1'($urandom()));
      else
        send_word(OP_UNUSED, 10'($urandom()), 6'($urandom()), $urandom(), 1'($urandom()));
    end
    no_gaps = 1'b0;
    send_word(OP_EMPTY, '0, '0, '0, 1'b0);
    idle_input();

    // Drain, then give stray words time to show up.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $error("%0d pooled words never arrived", sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0) $display("embedding_bag_sum_tb passed");
    else $display("embedding_bag_sum_tb failed");
    $finish;
  end

endmodule
